[rtl/core/deque_with_remove_by_value_top_defines.svh]
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_top_defines.svh
// Assertion macros for the deque block. Define ASSERT_OFF to strip them.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_TOP_DEFINES_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on the rising clock edge, disabled during reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an expression is never true.
`define DQ_ASSERT_NEVER(lbl, expr, msg) \
  `DQ_ASSERT(lbl, !(expr), msg)

`else

`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the deque block.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OPCODE_W     = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } dq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dq_status_e;

  // Per-cycle command broadcast to every cell, already qualified.
  typedef struct packed {
    logic add_back;
    logic push_front;
    logic pop_front;
    logic pop_back;
    logic remove;
  } dq_cmd_t;

endpackage

`default_nettype wire

[rtl/core/dq_in_if.sv]
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// Valid/ready channels of the deque: operation beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic signed [31:0]          value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dq_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          popped_value;
  logic [1:0]                  status;
  logic [4:0]                  entry_count;

  modport source (output valid, output popped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/core/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell
// One deque slot: holds an entry and its valid bit, shifts with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dq_pkg::dq_cmd_t            cmd_i,
  input  wire logic [dq_pkg::DATA_W-1:0]  value_i,
  input  wire logic [dq_pkg::DATA_W-1:0]  left_data_i,
  input  wire logic                       left_valid_i,
  input  wire logic [dq_pkg::DATA_W-1:0]  right_data_i,
  input  wire logic                       right_valid_i,
  input  wire logic                       found_i,
  output logic [dq_pkg::DATA_W-1:0]       data_o,
  output logic                            valid_o,
  output logic                            last_o,
  output logic                            found_o
);
  import dq_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;
  logic              tail_slot, match;

  assign tail_slot = !valid_q && left_valid_i;   // first free slot
  assign last_o    = valid_q && !right_valid_i;  // back entry
  assign match     = valid_q && (data_q == value_i);
  assign found_o   = found_i || match;           // first match at or ahead

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.add_back && tail_slot) begin
      data_d  = value_i;
      valid_d = 1'b1;
    end else if (cmd_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (cmd_i.pop_front || (cmd_i.remove && found_o)) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.pop_back && last_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/core/deque_with_remove_by_value_top.sv]
// Result beat: registered, valid in the cycle after its operation beat is taken.
// Throughput: one operation per cycle unless the output stalls; every cell compares and shifts at once.
// The remove search ripples a found flag along the chain of CAPACITY cells.
// Reset: asynchronous, active low; empties the deque and drops the result.
// Entry data is not reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_top
// Bounded double-ended queue with remove-by-value, built as a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deque_with_remove_by_value_top_defines.svh"

module deque_with_remove_by_value_top #(
  parameter int unsigned CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_in_if.sink     in_i,
  dq_out_if.source  out_o
);
  import dq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Cell chain wiring
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_last;
  logic [CAPACITY:0]   found;        // found[i]: match ahead of cell i

  dq_cmd_t           cmd;
  logic              fire;
  logic [CW-1:0]     count_q, count_d;
  logic              full, empty;

  // Result register
  logic              out_valid_q;
  logic [DATA_W-1:0] popped_q, popped_d;
  dq_status_e        status_q, status_d;
  logic [COUNT_OUT_W-1:0] ecount_q;

  logic [DATA_W-1:0] back_data;
  dq_op_e            op;

  // A new beat is taken whenever the result slot is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign op         = dq_op_e'(in_i.opcode);

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  // Back entry: the single cell whose successor is empty.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      back_data = back_data | (cell_data[i] & {DATA_W{cell_last[i]}});
    end
  end

  // Decode: qualify the command with full/empty, form the result.
  always_comb begin
    cmd      = '0;
    popped_d = '0;
    status_d = ST_OK;
    count_d  = count_q;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.add_back   = fire && (op == OP_PUSH_BACK);
          cmd.push_front = fire && (op == OP_PUSH_FRONT);
          count_d        = count_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.pop_front = fire;
          popped_d      = cell_data[0];
          count_d       = count_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.pop_back = fire;
          popped_d     = back_data;
          count_d      = count_q - CW'(1);
        end
      end
      OP_REMOVE: begin
        // Cells ahead of the first match hold; the rest shift toward front.
        cmd.remove = fire;
        if (found[CAPACITY]) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        // Unused opcodes: no change, ok status.
      end
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data;
    logic              left_valid, right_valid;

    if (g == 0) begin : g_front
      assign left_data  = in_i.value;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[g-1];
      assign left_valid = cell_valid[g-1];
    end

    if (g == int'(CAPACITY) - 1) begin : g_back
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[g+1];
      assign right_valid = cell_valid[g+1];
    end

    dq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .value_i       (in_i.value),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .found_i       (found[g]),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .last_o        (cell_last[g]),
      .found_o       (found[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      popped_q <= popped_d;
      status_q <= status_d;
      ecount_q <= COUNT_OUT_W'(count_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.status       = status_q;
  assign out_o.entry_count  = ecount_q;

  // Assertions
  `DQ_ASSERT_NEVER(a_count_bound, count_q > CW'(CAPACITY), "count above capacity")
  `DQ_ASSERT(a_valid_prefix, $countones(cell_valid) == int'(count_q),
             "cell valid bits disagree with count")
  `DQ_ASSERT(a_full_push, fire && full &&
             (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) |=> status_q == ST_FULL,
             "push on full not flagged")
  `DQ_ASSERT(a_empty_pop, fire && empty &&
             (op == OP_POP_FRONT || op == OP_POP_BACK) |=>
             status_q == ST_EMPTY && popped_q == '0,
             "pop on empty not flagged")

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Deque with remove-by-value: self-checking testbench
// Sends push, pop and remove beats with random gaps and stalls. A shadow deque
// in the bench predicts every result beat, which the monitor checks field by
// field, in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int unsigned WD_LIMIT     = 5000;  // cycles with no beat at all
  localparam int unsigned TAIL_CYCLES  = 8;     // each result is registered after its operation

  // One operation beat as the stimulus builder queues it.
  typedef struct {
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   value;
    int unsigned                gap;        // idle cycles after this beat
    bit                         wait_idle;  // hold until every result is back
  } op_beat_t;

  // One predicted result beat.
  typedef struct {
    logic signed [DATA_W-1:0]   popped_value;
    dq_status_e                 status;
    logic [COUNT_OUT_W-1:0]     entry_count;
  } dq_result_t;

  logic clk_i;
  logic rst_ni;

  dq_in_if  in_if ();
  dq_out_if out_if ();

  deque_with_remove_by_value_top #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow deque: entries held front first, index 0 is the front.
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int unsigned              shadow_fill;

  op_beat_t   pending_beats [$];
  dq_result_t expected_results [$];

  int unsigned beats_total;
  int unsigned beats_accepted;
  int unsigned results_seen;
  int unsigned n_fail;

  // Applies one operation to the shadow deque and returns its result beat.
  function automatic dq_result_t deque_apply(logic [OPCODE_W-1:0] op,
                                             logic signed [DATA_W-1:0] v);
    dq_result_t  r;
    int unsigned i;
    int unsigned hit;
    r.popped_value = '0;
    r.status       = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_fill] = v;
          shadow_fill++;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_fill; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = v;
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_entries[0];
          for (i = 0; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = shadow_entries[shadow_fill-1];
          shadow_fill--;
        end
      end
      OP_REMOVE: begin
        // first match seen from the front; the tail closes up behind it
        hit = shadow_fill;
        for (i = 0; i < shadow_fill; i++) begin
          if (hit == shadow_fill && shadow_entries[i] == v) hit = i;
        end
        if (hit == shadow_fill) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      default: ;  // unused opcodes leave everything as it is
    endcase
    r.entry_count = shadow_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued beats, holds them through backpressure, and
  // predicts each one at the edge where it is taken.
  // --------------------------------------------------------------------------
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    op_beat_t nxt;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= OP_PUSH_BACK;
      in_if.value  <= '0;
      gap_left     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.insert(expected_results.size(),
                                deque_apply(in_if.opcode, in_if.value));
        beats_accepted <= beats_accepted + 1;
      end
      // a beat that is offered but not taken stays put
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left != 0) begin
          in_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_beats.size() != 0 &&
                     (!pending_beats[0].wait_idle || expected_results.size() == 0)) begin
          nxt = pending_beats.pop_front();
          in_if.valid  <= 1'b1;
          in_if.opcode <= nxt.opcode;
          in_if.value  <= nxt.value;
          gap_left     <= nxt.gap;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: random stalls, calm stretches with none, and two long
  // hold-offs so the deque backs up into its input.
  // --------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned next_hold_at;
  int unsigned rx_cycle;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      next_hold_at <= 300;
      rx_cycle     <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (next_hold_at != 0 && results_seen >= next_hold_at) begin
        out_if.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES - 1;
        next_hold_at <= (next_hold_at < 800) ? 800 : 0;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        // a quarter of the time the receiver never stalls
        stall_left   <= (rx_cycle[7:6] == 2'd0) ? 0 : pick_idle();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dq_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        n_fail++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_if.popped_value !== exp_r.popped_value) begin
          $error("popped_value: expected %0d, got %0d", exp_r.popped_value,
                 out_if.popped_value);
          n_fail++;
        end
        if (out_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
          n_fail++;
        end
        if (out_if.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 out_if.entry_count);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a beat on either side means a hang.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // values that repeat, so removes find matches and duplicates
  logic signed [DATA_W-1:0] value_pool [8];
  bit                       calm_phase;

  task automatic queue_beat(logic [OPCODE_W-1:0] op, logic signed [DATA_W-1:0] v,
                            bit wait_idle);
    op_beat_t b;
    b.opcode    = op;
    b.value     = v;
    b.gap       = calm_phase ? 0 : pick_idle();
    b.wait_idle = wait_idle;
    pending_beats.insert(pending_beats.size(), b);
    beats_total++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return value_pool[$urandom_range(7)];
    if (r < 85) return $urandom();
    case ($urandom_range(3))
      0:       return 32'sh0000_0000;
      1:       return -32'sd1;
      2:       return 32'sh7fff_ffff;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  initial begin
    int unsigned n_rand;
    int unsigned phase;
    int unsigned len;
    int unsigned kind;
    int unsigned w_push;
    int unsigned w_pop;
    int unsigned r;
    bit          idle_first;
    logic signed [DATA_W-1:0] v;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.opcode = OP_PUSH_BACK;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    shadow_fill  = 0;
    beats_total  = 0;
    beats_accepted = 0;
    results_seen = 0;
    n_fail       = 0;
    quiet_cycles = 0;
    calm_phase   = 1'b0;

    // Directed: empty-queue corners, unused opcodes, extreme values, removes
    // at the back and the middle, and pops from both ends.
    queue_beat(OP_POP_FRONT,  '0, 1'b0);           // pop on empty
    queue_beat(OP_POP_BACK,   '0, 1'b0);
    queue_beat(OP_REMOVE,     '0, 1'b0);           // remove on empty
    queue_beat(3'd5,          -32'sd1, 1'b0);      // unused opcodes
    queue_beat(3'd6,          32'sh5555_5555, 1'b0);
    queue_beat(3'd7,          32'sh2aaa_aaaa, 1'b0);
    queue_beat(OP_PUSH_BACK,  32'sh7fff_ffff, 1'b0);
    queue_beat(OP_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    queue_beat(OP_PUSH_BACK,  -32'sd1, 1'b0);
    queue_beat(OP_PUSH_FRONT, 32'sh0000_0000, 1'b0);
    queue_beat(3'd7,          32'sh7fff_ffff, 1'b0);
    queue_beat(OP_REMOVE,     32'sh1234_5678, 1'b0); // no match
    queue_beat(OP_REMOVE,     -32'sd1, 1'b0);        // match at the tail end
    queue_beat(OP_REMOVE,     32'sh8000_0000, 1'b0); // match one from front
    queue_beat(OP_POP_FRONT,  '0, 1'b0);
    queue_beat(OP_POP_BACK,   '0, 1'b0);
    queue_beat(OP_POP_BACK,   '0, 1'b0);             // empty again

    // Random phases: fill-heavy, drain-heavy and mixed traffic. Fill phases
    // run the deque into full, drain phases into empty.
    foreach (value_pool[i]) value_pool[i] = $urandom_range(9);
    n_rand = 0;
    phase  = 0;
    while (n_rand < RANDOM_ITEMS) begin
      len        = $urandom_range(60, 20);
      kind       = $urandom_range(2);
      calm_phase = (phase % 4 == 3);
      // sender waits for every result now and then, always once early on
      idle_first = (phase == 4) || ($urandom_range(4) == 0);
      value_pool[$urandom_range(7)] = $urandom();
      value_pool[$urandom_range(7)] = $urandom_range(9);
      case (kind)
        0:       begin w_push = 70; w_pop = 12; end
        1:       begin w_push = 15; w_pop = 60; end
        default: begin w_push = 35; w_pop = 32; end
      endcase
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(99);
        v = pick_value();
        if (r < 3) begin
          queue_beat(OPCODE_W'($urandom_range(7, 5)), v, idle_first && k == 0);
        end else if (r < 3 + w_push) begin
          queue_beat($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, v,
                     idle_first && k == 0);
        end else if (r < 3 + w_push + w_pop) begin
          queue_beat($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, v,
                     idle_first && k == 0);
        end else begin
          queue_beat(OP_REMOVE, v, idle_first && k == 0);
        end
      end
      n_rand += len;
      phase++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_accepted != beats_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_in_if.sv
rtl/core/dq_cell.sv
rtl/core/deque_with_remove_by_value_top.sv
tb/testbench.sv
